// ----- sv/urlpd_pkg.sv -----
// Shared types, character codes and helper functions for the URL percent decoder.
`default_nettype none

package urlpd_pkg;

   localparam int unsigned MAX_OUT     = 3;
   localparam int unsigned CNT_W       = $clog2(MAX_OUT + 1);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef enum logic [1:0] {
      HOLD_NONE  = 2'd0,
      HOLD_PCT   = 2'd1,
      HOLD_DIGIT = 2'd2
   } hold_type;

   // One decoded group: the bytes that a single input transfer produces.
   typedef struct packed {
      logic [CNT_W-1:0]           count;
      logic [MAX_OUT-1:0][7:0]    data;
      logic                       last;
   } group_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      if (c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61) begin
         d = c - 8'h57;
      end else begin
         d = c - 8'h37;
      end
      return d[3:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/urlpd_front.sv -----
// Front end: accepts raw bytes, tracks held escape characters and builds output groups.
`default_nettype none

module urlpd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,
   input  wire logic                 req_tlast,
   input  wire logic                 q_full,
   output logic                      q_push,
   output urlpd_pkg::group_type      q_wr
);
   import urlpd_pkg::*;

   hold_type   hold_ff, hold_in;
   logic [7:0] digit_ff, digit_in;
   logic       accept;
   logic       fresh;
   logic [CNT_W-1:0] n;
   logic [MAX_OUT-1:0][7:0] bytes;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      n        = '0;
      bytes    = '0;
      hold_in  = hold_ff;
      digit_in = digit_ff;
      fresh    = 1'b0;

      unique case (hold_ff)
         HOLD_PCT: begin
            if (is_hex(req_tdata)) begin
               hold_in  = HOLD_DIGIT;
               digit_in = req_tdata;
            end else begin
               bytes[0] = CH_PERCENT;
               n        = CNT_W'(1);
               hold_in  = HOLD_NONE;
               fresh    = 1'b1;
            end
         end
         HOLD_DIGIT: begin
            hold_in = HOLD_NONE;
            if (is_hex(req_tdata)) begin
               bytes[0] = {hex_value(digit_ff), hex_value(req_tdata)};
               n        = CNT_W'(1);
            end else begin
               bytes[0] = CH_PERCENT;
               bytes[1] = digit_ff;
               n        = CNT_W'(2);
               fresh    = 1'b1;
            end
         end
         default: begin
            hold_in = HOLD_NONE;
            fresh   = 1'b1;
         end
      endcase

      // A byte that breaks an escape is decoded as if nothing were held.
      if (fresh) begin
         if (req_tdata == CH_PLUS) begin
            bytes[n[1:0]] = CH_SPACE;
            n             = n + CNT_W'(1);
         end else if (req_tdata == CH_PERCENT) begin
            hold_in = HOLD_PCT;
         end else begin
            bytes[n[1:0]] = req_tdata;
            n             = n + CNT_W'(1);
         end
      end

      // The final byte of a string flushes whatever is still held.
      if (req_tlast) begin
         if (hold_in != HOLD_NONE) begin
            bytes[n[1:0]] = CH_PERCENT;
            n             = n + CNT_W'(1);
         end
         if (hold_in == HOLD_DIGIT) begin
            bytes[n[1:0]] = digit_in;
            n             = n + CNT_W'(1);
         end
         hold_in = HOLD_NONE;
      end
   end

   assign q_push     = accept && (n != '0);
   assign q_wr.count = n;
   assign q_wr.data  = bytes;
   assign q_wr.last  = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_NONE;
      end else if (accept) begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else if (accept) begin
         digit_ff <= digit_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/urlpd_queue.sv -----
// Two-entry queue of decoded groups between the front and back ends.
`default_nettype none

module urlpd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire urlpd_pkg::group_type wr,
   input  wire logic                 pop,
   output urlpd_pkg::group_type      head,
   output logic                      empty,
   output logic                      full
);
   import urlpd_pkg::*;

   group_type         entry_ff [QUEUE_DEPTH];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop  ? !rptr_ff : rptr_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= wr;
      end
   end

endmodule

`default_nettype wire

// ----- sv/urlpd_back.sv -----
// Back end: unpacks queued groups into single output bytes through an output register.
`default_nettype none

module urlpd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire urlpd_pkg::group_type head,
   input  wire logic                 empty,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);
   import urlpd_pkg::*;

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       data_ff;
   logic             last_ff;
   logic             load;
   logic             final_byte;

   assign load       = !empty && (!valid_ff || rsp_tready);
   assign final_byte = (idx_ff == head.count - CNT_W'(1));
   assign pop        = load && final_byte;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_byte ? '0 : idx_ff + CNT_W'(1);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head.data[idx_ff[1:0]];
         last_ff <= head.last && final_byte;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ----- sv/url_percent_decoder_core.sv -----
// Top level of the streaming URL percent decoder for form-encoded text.
`default_nettype none

// Decodes a form-encoded byte stream: '+' becomes a space, '%' with two hex
// digits becomes one byte, and a broken escape is passed through literally.
// Bytes enter one per cycle while the queue is not full, and decoded bytes leave
// one per cycle while the receiver is ready; an input byte yields 0 to 3 output bytes.
// The front end registers its decoding into a two-group queue, and the back
// end drains that queue one byte per cycle, while the receiver is ready,
// through the output register, so a decoded byte passes through a queue entry
// and then the output register before it is valid at the output.
// The input stalls only while the queue holds two groups.
module url_percent_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast
);
   import urlpd_pkg::*;

   group_type q_wr;
   group_type q_head;
   logic      q_push;
   logic      q_pop;
   logic      q_empty;
   logic      q_full;

   urlpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wr       (q_wr)
   );

   urlpd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wr    (q_wr),
      .pop   (q_pop),
      .head  (q_head),
      .empty (q_empty),
      .full  (q_full)
   );

   urlpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The front end never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("group pushed into a full queue");

   // Every queued group carries at least one byte and no more than MAX_OUT.
   a_group_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_wr.count != '0) && (q_wr.count <= CNT_W'(MAX_OUT)))
      else $error("group with a bad byte count");

   // The back end only retires a group that is present.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("group popped from an empty queue");

endmodule

`default_nettype wire
